// File: rtl/dptt_pkg.sv
// ----------------------------------------------------------------------------
// dptt_pkg: shared types and constants of the transposition table
// Beat types for the request and response channels, the layout of one slot
// in the table memory, and the request codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dptt_pkg;

   // Table geometry: slot index is the low bits of the key
   localparam int TABLE_DEPTH = 65536;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);

   // Request codes; the spare code behaves as a lookup
   typedef enum logic [1:0] {
      REQ_LOOKUP   = 2'd0,
      REQ_ADD      = 2'd1,
      REQ_ADD_LEAF = 2'd2,
      REQ_SPARE    = 2'd3
   } dptt_op_type;

   // One request beat
   typedef struct packed {
      dptt_op_type req_type;
      logic [31:0] key;
      logic [7:0]  move_x;
      logic [7:0]  move_y;
      logic [7:0]  search_depth;
      logic [7:0]  calc_depth;
      logic [31:0] score;
   } dptt_req_type;

   // One response beat
   typedef struct packed {
      logic        hit;
      logic        slot_valid;
      logic [31:0] stored_key;
      logic [7:0]  stored_depth;
      logic [7:0]  stored_calc_depth;
      logic [31:0] stored_score;
      logic [7:0]  stored_x;
      logic [7:0]  stored_y;
      logic        written;
   } dptt_rsp_type;

   // One slot of the table memory
   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [7:0]  search_depth;
      logic [7:0]  calc_depth;
      logic [31:0] score;
      logic [7:0]  move_x;
      logic [7:0]  move_y;
   } dptt_entry_type;

endpackage

`default_nettype wire

// File: rtl/depth_preferred_transposition_table.sv
// ----------------------------------------------------------------------------
// depth_preferred_transposition_table: direct-mapped search result cache
// Each request reads its slot, applies the depth-preferred replacement rule
// and writes the slot back, then reports the slot contents after the update.
// ----------------------------------------------------------------------------
//
//   channel   ports                     handshake
//   request   req_data                  accepted when start && !busy
//   response  rsp_data                  valid for one cycle with rsp_strobe
//
// One request per cycle while busy is low. The slot memory read is registered
// with the request; the update, the write-back and the registered response
// follow. A request that hits the slot written in the cycle before reads the
// forwarded word instead of the memory.
// After reset a clearing pass walks every slot index and zeroes the whole
// slot; busy stays high meanwhile.
// The response side cannot stall.
`default_nettype none

module depth_preferred_transposition_table (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  dptt_pkg::dptt_req_type req_data,
   output logic                  rsp_strobe,
   output dptt_pkg::dptt_rsp_type rsp_data
);
   import dptt_pkg::*;

   // Slot memory
   dptt_entry_type slot_mem [TABLE_DEPTH];

   // Control state
   logic             clr_ff, clr_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic             s1_ff;
   logic             fwd_ff;
   logic             rsp_strobe_ff;

   // Payload state
   dptt_req_type     req_ff;
   dptt_entry_type   rd_ff;
   dptt_entry_type   fwd_word_ff;
   logic [IDX_W-1:0] fwd_idx_ff;
   dptt_rsp_type     rsp_ff, rsp_in;

   logic             accept;
   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] cur_idx;
   dptt_entry_type   new_word;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   dptt_entry_type   mem_wdata;

   assign busy    = clr_ff;
   assign accept  = start && !clr_ff;
   assign req_idx = req_data.key[IDX_W-1:0];
   assign cur_idx = req_ff.key[IDX_W-1:0];

   // Advance the clearing pass
   always_comb begin
      clr_in     = clr_ff;
      clr_idx_in = clr_idx_ff;
      if (clr_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == IDX_W'(TABLE_DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   // Update one slot and form the response
   always_comb begin
      dptt_entry_type old_word;
      logic           same;
      logic           put_data;
      logic           put_move;
      logic signed [8:0] new_margin;
      logic signed [8:0] old_margin;

      old_word   = (fwd_ff && fwd_idx_ff == cur_idx) ? fwd_word_ff : rd_ff;
      same       = old_word.valid && old_word.key == req_ff.key;
      new_margin = $signed({1'b0, req_ff.calc_depth}) - $signed({1'b0, req_ff.search_depth});
      old_margin = $signed({1'b0, old_word.calc_depth})
                   - $signed({1'b0, old_word.search_depth});
      put_data   = 1'b0;
      put_move   = 1'b0;

      case (req_ff.req_type)
         REQ_ADD: begin
            if (!old_word.valid) begin
               put_data = 1'b1;
            end else if (same) begin
               put_data = new_margin > old_margin;
            end else begin
               put_data = req_ff.search_depth < old_word.search_depth;
            end
            put_move = put_data;
         end
         REQ_ADD_LEAF: begin
            if (!old_word.valid) begin
               put_data = 1'b1;
            end else if (!same) begin
               put_data = req_ff.search_depth < old_word.search_depth;
            end
         end
         default: begin
            put_data = 1'b0;
         end
      endcase

      new_word = old_word;
      if (put_data) begin
         new_word.valid        = 1'b1;
         new_word.key          = req_ff.key;
         new_word.search_depth = req_ff.search_depth;
         new_word.calc_depth   = req_ff.calc_depth;
         new_word.score        = req_ff.score;
      end
      if (put_move) begin
         new_word.move_x = req_ff.move_x;
         new_word.move_y = req_ff.move_y;
      end

      // Empty slots report zero data but still show the move
      rsp_in.hit               = new_word.valid && new_word.key == req_ff.key;
      rsp_in.slot_valid        = new_word.valid;
      rsp_in.stored_key        = new_word.valid ? new_word.key : 32'd0;
      rsp_in.stored_depth      = new_word.valid ? new_word.search_depth : 8'd0;
      rsp_in.stored_calc_depth = new_word.valid ? new_word.calc_depth : 8'd0;
      rsp_in.stored_score      = new_word.valid ? new_word.score : 32'd0;
      rsp_in.stored_x          = new_word.move_x;
      rsp_in.stored_y          = new_word.move_y;
      rsp_in.written           = put_data;
   end

   // Select the write port source: clearing pass or slot update
   always_comb begin
      mem_we    = clr_ff || s1_ff;
      mem_waddr = clr_ff ? clr_idx_ff : cur_idx;
      mem_wdata = new_word;
      if (clr_ff) begin
         mem_wdata        = '0;
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= slot_mem[req_idx];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= 1'b1;
         clr_idx_ff    <= '0;
         s1_ff         <= 1'b0;
         fwd_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         clr_ff        <= clr_in;
         clr_idx_ff    <= clr_idx_in;
         s1_ff         <= accept;
         fwd_ff        <= s1_ff;
         rsp_strobe_ff <= s1_ff;
      end
   end

   // Payload registers: hold the request, the forwarded word and the response
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      fwd_word_ff <= new_word;
      fwd_idx_ff  <= cur_idx;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/dptt_checker.sv
// ----------------------------------------------------------------------------
// dptt_checker: port-level checks of the transposition table
// Watches request and response beats and the busy flag over time.
// ----------------------------------------------------------------------------
`default_nettype none

module dptt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input dptt_pkg::dptt_req_type req_data,
   input logic                   rsp_strobe,
   input dptt_pkg::dptt_rsp_type rsp_data
);
   import dptt_pkg::*;

   // Every accepted beat is answered by a response strobe
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted request got no response");

   // No response without an accepted request before it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("response without request");

   // Empty slot reports no hit and zero data
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.slot_valid) |->
         (!rsp_data.hit && !rsp_data.written && rsp_data.stored_key == 32'd0 &&
          rsp_data.stored_depth == 8'd0 && rsp_data.stored_calc_depth == 8'd0 &&
          rsp_data.stored_score == 32'd0))
      else $error("empty slot reported data");

   // A written slot holds the request's key and depth
   a_written_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.written) |->
         (rsp_data.hit && rsp_data.stored_key == $past(req_data.key, 2) &&
          rsp_data.stored_depth == $past(req_data.search_depth, 2)))
      else $error("written slot does not hold request data");

   // Clearing pass starts right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("not busy after reset");

endmodule

bind depth_preferred_transposition_table dptt_checker u_dptt_checker (.*);

`default_nettype wire

// File: dv/depth_preferred_transposition_table_tb.sv
// ----------------------------------------------------------------------------
// depth_preferred_transposition_table_tb: self-checking bench of the table
// Waits out the clearing pass after reset, then drives a short table of
// directed requests followed by about 1500 random lookups, adds, leaf adds and
// spare requests, mostly aimed at a few crowded slots. Every response beat is
// checked field by field against its typed row or the bench's model of the replacement rules.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_preferred_transposition_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dptt_pkg::*;

   localparam int RANDOM_REQS = 1500;
   localparam int MAX_GAP     = 11;

   // One row of the directed table
   typedef struct {
      dptt_req_type req;
      bit           typed;
      dptt_rsp_type rsp;
   } probe_row_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   dptt_req_type req_data;
   logic         rsp_strobe;
   dptt_rsp_type rsp_data;

   // Bench copy of the table, keyed by slot index; absent slots are cleared
   dptt_entry_type slot_model [logic [IDX_W-1:0]];
   dptt_rsp_type   slot_report_q [$];
   probe_row_type  probe_table [$];

   int unsigned n_mismatch;
   int unsigned n_reports;
   int unsigned n_written;
   int unsigned n_hits;

   depth_preferred_transposition_table uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Free-running clock, 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic dptt_req_type mk_req(dptt_op_type op, logic [31:0] key,
                                           logic [7:0] mx, logic [7:0] my,
                                           logic [7:0] sd, logic [7:0] cd,
                                           logic [31:0] sc);
      dptt_req_type r;
      r.req_type     = op;
      r.key          = key;
      r.move_x       = mx;
      r.move_y       = my;
      r.search_depth = sd;
      r.calc_depth   = cd;
      r.score        = sc;
      return r;
   endfunction

   function automatic dptt_rsp_type mk_rsp(logic h, logic v, logic [31:0] key,
                                           logic [7:0] sd, logic [7:0] cd,
                                           logic [31:0] sc, logic [7:0] mx,
                                           logic [7:0] my, logic w);
      dptt_rsp_type r;
      r.hit               = h;
      r.slot_valid        = v;
      r.stored_key        = key;
      r.stored_depth      = sd;
      r.stored_calc_depth = cd;
      r.stored_score      = sc;
      r.stored_x          = mx;
      r.stored_y          = my;
      r.written           = w;
      return r;
   endfunction

   // Apply the depth-preferred replacement rule to one slot and report it
   function automatic dptt_rsp_type predict_slot_update(dptt_req_type r);
      logic [IDX_W-1:0] idx;
      dptt_entry_type   e;
      dptt_rsp_type     o;
      bit               same_key;
      bit               put_data;
      int               new_span;
      int               old_span;
      idx      = r.key[IDX_W-1:0];
      e        = slot_model.exists(idx) ? slot_model[idx] : '0;
      same_key = e.valid && (e.key == r.key);
      put_data = 1'b0;
      new_span = int'(r.calc_depth) - int'(r.search_depth);
      old_span = int'(e.calc_depth) - int'(e.search_depth);
      case (r.req_type)
         REQ_ADD: begin
            if (!e.valid) put_data = 1'b1;
            else if (same_key) put_data = new_span > old_span;
            else put_data = r.search_depth < e.search_depth;
         end
         REQ_ADD_LEAF: begin
            if (!e.valid) put_data = 1'b1;
            else if (!same_key) put_data = r.search_depth < e.search_depth;
         end
         default: ;
      endcase
      if (put_data) begin
         e.valid        = 1'b1;
         e.key          = r.key;
         e.search_depth = r.search_depth;
         e.calc_depth   = r.calc_depth;
         e.score        = r.score;
         // leaf adds never touch the move
         if (r.req_type == REQ_ADD) begin
            e.move_x = r.move_x;
            e.move_y = r.move_y;
         end
         slot_model[idx] = e;
      end
      o = mk_rsp(e.valid && (e.key == r.key), e.valid,
                 e.valid ? e.key : 32'd0,
                 e.valid ? e.search_depth : 8'd0,
                 e.valid ? e.calc_depth : 8'd0,
                 e.valid ? e.score : 32'd0,
                 e.move_x, e.move_y, put_data);
      return o;
   endfunction

   function automatic void check_field(string fname, logic [31:0] exp_v,
                                       logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t ns: %s mismatch, expected %h actual %h",
                  $time, fname, exp_v, act_v);
         n_mismatch++;
      end
   endfunction

   // Present one request beat, hold it until accepted, then idle for the given gap
   task automatic drive_beat(input dptt_req_type beat, input int unsigned gap,
                             input bit use_typed, input dptt_rsp_type typed_rsp);
      dptt_rsp_type predicted;
      req_data <= beat;
      start    <= 1'b1;
      @(negedge clock);
      while (busy !== 1'b0) @(negedge clock);
      @(posedge clock);
      predicted = predict_slot_update(beat);
      slot_report_q.push_back(use_typed ? typed_rsp : predicted);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Check each response beat against the oldest expectation
   always @(negedge clock) begin
      dptt_rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         n_reports++;
         if (rsp_data.written === 1'b1) n_written++;
         if (rsp_data.hit === 1'b1) n_hits++;
         if (slot_report_q.size() == 0) begin
            $display("%0t ns: unexpected response beat, expected none actual %h",
                     $time, rsp_data);
            n_mismatch++;
         end else begin
            want = slot_report_q.pop_front();
            check_field("hit", 32'(want.hit), 32'(rsp_data.hit));
            check_field("slot_valid", 32'(want.slot_valid), 32'(rsp_data.slot_valid));
            check_field("stored_key", want.stored_key, rsp_data.stored_key);
            check_field("stored_depth", 32'(want.stored_depth),
                        32'(rsp_data.stored_depth));
            check_field("stored_calc_depth", 32'(want.stored_calc_depth),
                        32'(rsp_data.stored_calc_depth));
            check_field("stored_score", want.stored_score, rsp_data.stored_score);
            check_field("stored_x", 32'(want.stored_x), 32'(rsp_data.stored_x));
            check_field("stored_y", 32'(want.stored_y), 32'(rsp_data.stored_y));
            check_field("written", 32'(want.written), 32'(rsp_data.written));
         end
      end
   end

   // Bound the run: clearing pass plus every beat at its longest gap, many times over
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [31:0]  idx_pool [8];
      logic [31:0]  tag_pool [4];
      dptt_req_type beat;
      dptt_op_type  op;
      logic [31:0]  key;
      logic [7:0]   sd;
      logic [7:0]   cd;
      int unsigned  pick;
      int unsigned  gap;
      bit           no_idle;

      n_mismatch = 0;
      n_reports  = 0;
      n_written  = 0;
      n_hits     = 0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;

      // Directed rows: empty slots, extremes, every request code, all rule branches
      probe_table.push_back('{mk_req(REQ_LOOKUP, 32'h0, 8'h0, 8'h0, 8'h0, 8'h0, 32'h0),
         1'b1, mk_rsp(1'b0, 1'b0, 32'h0, 8'h0, 8'h0, 32'h0, 8'h0, 8'h0, 1'b0)});
      probe_table.push_back('{mk_req(REQ_SPARE, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
         8'hFF, 8'hFF, 32'hFFFF_FFFF),
         1'b1, mk_rsp(1'b0, 1'b0, 32'h0, 8'h0, 8'h0, 32'h0, 8'h0, 8'h0, 1'b0)});
      probe_table.push_back('{mk_req(REQ_ADD, 32'h0000_0010, 8'hFF, 8'hFF, 8'd10, 8'd20,
         32'hFFFF_FFFF),
         1'b1, mk_rsp(1'b1, 1'b1, 32'h0000_0010, 8'd10, 8'd20, 32'hFFFF_FFFF, 8'hFF,
         8'hFF, 1'b1)});
      probe_table.push_back('{mk_req(REQ_LOOKUP, 32'h0000_0010, 8'h0, 8'h0, 8'h0, 8'h0,
         32'h0),
         1'b1, mk_rsp(1'b1, 1'b1, 32'h0000_0010, 8'd10, 8'd20, 32'hFFFF_FFFF, 8'hFF,
         8'hFF, 1'b0)});
      // same key: equal span keeps, wider span replaces, negative span keeps
      probe_table.push_back('{mk_req(REQ_ADD, 32'h0000_0010, 8'h11, 8'h22, 8'd10, 8'd20,
         32'h1), 1'b0, '0});
      probe_table.push_back('{mk_req(REQ_ADD, 32'h0000_0010, 8'h33, 8'h44, 8'd0, 8'd255,
         32'h2), 1'b0, '0});
      probe_table.push_back('{mk_req(REQ_ADD, 32'h0000_0010, 8'h55, 8'h66, 8'd255, 8'd0,
         32'h3), 1'b0, '0});
      // clash on a slot holding depth zero: never replaced
      probe_table.push_back('{mk_req(REQ_ADD, 32'h0001_0010, 8'h77, 8'h88, 8'd255, 8'd1,
         32'h4), 1'b0, '0});
      probe_table.push_back('{mk_req(REQ_ADD_LEAF, 32'h0000_0010, 8'h99, 8'hAA, 8'd0,
         8'd0, 32'h5), 1'b0, '0});
      // leaf fills an empty slot and keeps the cleared move
      probe_table.push_back('{mk_req(REQ_ADD_LEAF, 32'hABCD_0020, 8'hEE, 8'hDD, 8'd100,
         8'd5, 32'h1234_5678),
         1'b1, mk_rsp(1'b1, 1'b1, 32'hABCD_0020, 8'd100, 8'd5, 32'h1234_5678, 8'h0,
         8'h0, 1'b1)});
      probe_table.push_back('{mk_req(REQ_ADD_LEAF, 32'h1111_0020, 8'hEE, 8'hDD, 8'd50,
         8'd60, 32'h8000_0000), 1'b0, '0});
      probe_table.push_back('{mk_req(REQ_ADD, 32'h2222_0020, 8'h5A, 8'hA5, 8'd49, 8'd40,
         32'h7FFF_FFFF), 1'b0, '0});
      probe_table.push_back('{mk_req(REQ_ADD_LEAF, 32'h3333_0020, 8'h01, 8'h02, 8'd200,
         8'd0, 32'h0), 1'b0, '0});
      probe_table.push_back('{mk_req(REQ_ADD_LEAF, 32'h2222_0020, 8'h01, 8'h02, 8'd0,
         8'd255, 32'h9), 1'b0, '0});
      probe_table.push_back('{mk_req(REQ_ADD, 32'h2222_0020, 8'hC3, 8'h3C, 8'd48, 8'd40,
         32'hA), 1'b0, '0});
      probe_table.push_back('{mk_req(REQ_ADD, 32'h4444_0020, 8'h0F, 8'hF0, 8'd47, 8'd255,
         32'hB), 1'b0, '0});
      probe_table.push_back('{mk_req(REQ_SPARE, 32'h4444_0020, 8'h0, 8'h0,
         8'h0, 8'h0, 32'h0), 1'b0, '0});
      // top slot, all-zero and all-one extremes
      probe_table.push_back('{mk_req(REQ_ADD, 32'hFFFF_FFFF, 8'h0, 8'h0, 8'd0, 8'd0,
         32'h0),
         1'b1, mk_rsp(1'b1, 1'b1, 32'hFFFF_FFFF, 8'd0, 8'd0, 32'h0, 8'h0, 8'h0, 1'b1)});
      probe_table.push_back('{mk_req(REQ_ADD, 32'h0000_FFFF, 8'hFF, 8'hFF, 8'd0, 8'd255,
         32'hFFFF_FFFF),
         1'b1, mk_rsp(1'b0, 1'b1, 32'hFFFF_FFFF, 8'd0, 8'd0, 32'h0, 8'h0, 8'h0, 1'b0)});
      probe_table.push_back('{mk_req(REQ_LOOKUP, 32'h0000_FFFF, 8'h0, 8'h0, 8'h0, 8'h0,
         32'h0), 1'b0, '0});

      // Hold reset, then release it once
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; mostly back to back to hit forwarding
      foreach (probe_table[i]) begin
         gap = (i % 3 == 2) ? $urandom_range(0, MAX_GAP) : 0;
         drive_beat(probe_table[i].req, gap, probe_table[i].typed, probe_table[i].rsp);
      end

      // Crowd traffic onto a few slots, each shared by a few keys
      foreach (idx_pool[i]) idx_pool[i] = $urandom();
      idx_pool[0] = 32'h0;
      idx_pool[1] = 32'hFFFF;
      foreach (tag_pool[i]) tag_pool[i] = $urandom();

      no_idle = 1'b0;
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
         // drain once in a while so the sender sees an empty pipe
         if (n % 250 == 125) begin
            start <= 1'b0;
            while (slot_report_q.size() != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         op = (pick < 30) ? REQ_LOOKUP :
              (pick < 65) ? REQ_ADD :
              (pick < 90) ? REQ_ADD_LEAF : REQ_SPARE;
         if ($urandom_range(0, 99) < 85)
            key = {tag_pool[2'($urandom_range(0, 3))][31:IDX_W],
                   idx_pool[3'($urandom_range(0, 7))][IDX_W-1:0]};
         else
            key = $urandom();
         if ($urandom_range(0, 99) < 70) begin
            sd = 8'($urandom_range(0, 15));
            cd = 8'($urandom_range(0, 15));
         end else begin
            sd = 8'($urandom_range(0, 255));
            cd = 8'($urandom_range(0, 255));
         end
         beat = mk_req(op, key, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       sd, cd, $urandom());
         gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         drive_beat(beat, gap, 1'b0, '0);
      end
      start <= 1'b0;

      // Drain, then give the two-stage pipe time to show any stray beat
      while (slot_report_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d response beats after the clearing pass: %0d slot writes, %0d hits,",
               n_reports, n_written, n_hits);
      $display("on crowded slots with same-key and clashing-key adds, leaf adds and lookups.");
      if (n_mismatch == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
